// ===== src/scfr_pkg.sv =====
`default_nettype none

package scfr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd255;
    localparam logic [BYTE_W-1:0] DEVICE_ID_RESET = 8'd252;
    localparam logic [BYTE_W-1:0] SHORT_LEN = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ID = 1'd1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID = 3'd1,
        PH_LEN = 3'd2,
        PH_TYPE = 3'd3,
        PH_DATA = 3'd4
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic              kind;
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] byte_index;
        logic              frame_ok;
    } t_result;

endpackage

`default_nettype wire

// ===== src/scfr_parser.sv =====
`default_nettype none

module scfr_parser (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire logic [scfr_pkg::BYTE_W-1:0] i_byte,
    input  wire logic [scfr_pkg::BYTE_W-1:0] i_header_byte,
    input  wire logic [scfr_pkg::BYTE_W-1:0] i_device_id,
    output scfr_pkg::t_result           o_result
);
    import scfr_pkg::*;

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_remaining, n_remaining;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_length, n_length;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] type_sum;
    logic [BYTE_W-1:0] id_expect;
    logic              data_end;

    assign type_sum  = r_length + i_byte;
    assign id_expect = i_device_id - 8'd1;
    assign data_end  = (r_remaining <= 8'd1);

    // next phase
    always_comb begin
        case (r_phase)
            PH_ID: begin
                n_phase = (i_byte == id_expect) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_phase = (r_length < SHORT_LEN) ? PH_HUNT : PH_DATA;
            end
            PH_DATA: begin
                n_phase = data_end ? PH_HUNT : PH_DATA;
            end
            default: begin
                n_phase = (i_byte == i_header_byte) ? PH_ID : PH_HUNT;
            end
        endcase
    end

    // frame registers and result
    always_comb begin
        n_remaining = r_remaining;
        n_sum       = r_sum;
        n_length    = r_length;
        n_type      = r_type;
        n_count     = r_count;
        o_result    = '0;
        o_result.frame_type = r_type;
        case (r_phase)
            PH_LEN: begin
                n_length = i_byte;
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_sum   = type_sum;
                n_count = '0;
                if (r_length < SHORT_LEN) begin
                    o_result.valid      = 1'b1;
                    o_result.kind       = KIND_END;
                    o_result.frame_type = i_byte;
                    o_result.frame_ok   = (type_sum == '0);
                end else begin
                    n_remaining = r_length - LEN_OVERHEAD;
                end
            end
            PH_DATA: begin
                o_result.valid      = 1'b1;
                o_result.byte_index = r_count;
                if (data_end) begin
                    n_remaining       = '0;
                    o_result.kind     = KIND_END;
                    o_result.frame_ok = (r_sum == i_byte);
                end else begin
                    n_remaining           = r_remaining - 8'd1;
                    n_sum                 = r_sum + i_byte;
                    n_count               = r_count + 8'd1;
                    o_result.kind         = KIND_PAYLOAD;
                    o_result.payload_byte = i_byte;
                end
            end
            default: begin
            end
        endcase
        if (!i_advance) begin
            o_result.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_remaining <= '0;
            r_sum       <= '0;
            r_length    <= '0;
            r_type      <= '0;
            r_count     <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
            r_length    <= n_length;
            r_type      <= n_type;
            r_count     <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== src/scfr_out_stage.sv =====
`default_nettype none

module scfr_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire scfr_pkg::t_result i_result,
    output logic                   o_can_take,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output scfr_pkg::t_result      o_result
);
    import scfr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/sum_checked_frame_receiver.sv =====
// Serial frame receiver with an 8-bit additive checksum.
// Input channel: one received byte per item on i_rx_byte, valid/ready.
// Output channel: payload items (kind 0, byte and its index) and one
// end-of-frame item per frame (kind 1, last high, frame_ok, payload count).
// Header, id and length bytes, and dropped bytes while hunting, give no item.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index at the clock
// edge (0 header byte, 1 device id); write only while the block is idle.
// Datapath: an input register feeds the frame parser, whose result goes to
// an output register. A byte's result is loaded into the output register
// when the parser advances. Throughput is one byte per cycle while the output
// is not stalled, set by the single parser pass between the two registers.
// If the output is stalled with a result waiting, the input register can
// still take one byte; further bytes wait with o_in_ready low until the
// result is taken. No item is lost or repeated.
// Reset (synchronous, active low) empties both registers, restores the
// config defaults and puts the parser back to hunting for a header.
`default_nettype none

module sum_checked_frame_receiver (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [scfr_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                        i_cfg_we,
    input  wire logic [scfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [scfr_pkg::BYTE_W-1:0] i_cfg_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_result_kind,
    output logic [scfr_pkg::BYTE_W-1:0]      o_frame_type,
    output logic [scfr_pkg::BYTE_W-1:0]      o_payload_byte,
    output logic [scfr_pkg::BYTE_W-1:0]      o_byte_index,
    output logic                             o_frame_ok,
    output logic                             o_last
);
    import scfr_pkg::*;

    logic [BYTE_W-1:0] r_header_byte;
    logic [BYTE_W-1:0] r_device_id;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              advance;
    logic              out_can_take;
    t_result           parse_result;
    t_result           out_result;

    assign advance    = r_in_valid && out_can_take;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_RESET;
            r_device_id   <= DEVICE_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_BYTE: r_header_byte <= i_cfg_data;
                REG_DEVICE_ID:   r_device_id   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    scfr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_byte        (r_in_byte),
        .i_header_byte (r_header_byte),
        .i_device_id   (r_device_id),
        .o_result      (parse_result)
    );

    scfr_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (parse_result),
        .o_can_take (out_can_take),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_result_kind  = out_result.kind;
    assign o_frame_type   = out_result.frame_type;
    assign o_payload_byte = out_result.payload_byte;
    assign o_byte_index   = out_result.byte_index;
    assign o_frame_ok     = out_result.frame_ok;
    assign o_last         = out_result.kind;

endmodule

`default_nettype wire

// ===== src/scfr_checker.sv =====
`default_nettype none

module scfr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic                        o_result_kind,
    input wire logic [scfr_pkg::BYTE_W-1:0] o_payload_byte,
    input wire logic                        o_frame_ok,
    input wire logic                        o_last
);
    import scfr_pkg::*;

    // a stalled item stays on the output
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == o_result_kind))
        else $error("last and result kind disagree");

    a_payload_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_PAYLOAD) |-> !o_frame_ok)
        else $error("frame_ok set on a payload item");

    a_end_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (o_payload_byte == '0))
        else $error("payload byte not zero at end of frame");

endmodule

bind sum_checked_frame_receiver scfr_checker u_scfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_kind  (o_result_kind),
    .o_payload_byte (o_payload_byte),
    .o_frame_ok     (o_frame_ok),
    .o_last         (o_last)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import scfr_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_result_kind;
    logic [BYTE_W-1:0]    o_frame_type;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [BYTE_W-1:0]    o_byte_index;
    logic                 o_frame_ok;
    logic                 o_last;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] pbyte;
        logic [BYTE_W-1:0] idx;
        logic              ok;
        logic              last;
    } t_frame_item;

    class frame_scoreboard;
        logic [BYTE_W-1:0] hdr_byte;
        logic [BYTE_W-1:0] dev_id;
        t_phase            ph;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] count;
        t_frame_item       expected_items[$];
        int                errors;

        function new();
            hdr_byte = HEADER_RESET;
            dev_id = DEVICE_ID_RESET;
            ph = PH_HUNT;
            left = '0;
            sum = '0;
            len = '0;
            ftype = '0;
            count = '0;
            errors = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
            if (idx == REG_HEADER_BYTE) begin
                hdr_byte = val;
            end else if (idx == REG_DEVICE_ID) begin
                dev_id = val;
            end
        endfunction

        function void push_item(input logic kind, input logic [BYTE_W-1:0] pbyte,
                                input logic [BYTE_W-1:0] idx, input logic ok);
            t_frame_item it;
            it.kind = kind;
            it.ftype = ftype;
            it.pbyte = pbyte;
            it.idx = idx;
            it.ok = ok;
            it.last = kind;
            expected_items.insert(expected_items.size(), it);
        endfunction

        function void note_byte(input logic [BYTE_W-1:0] b);
            case (ph)
                PH_ID: begin
                    ph = (b == dev_id - 8'd1) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    len = b;
                    ph = PH_TYPE;
                end
                PH_TYPE: begin
                    ftype = b;
                    sum = len + b;
                    count = '0;
                    if (len < SHORT_LEN) begin
                        // short frame ends on the type byte
                        ph = PH_HUNT;
                        push_item(KIND_END, '0, '0, sum == '0);
                    end else begin
                        left = len - LEN_OVERHEAD;
                        ph = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (left <= 8'd1) begin
                        ph = PH_HUNT;
                        left = '0;
                        push_item(KIND_END, '0, count, sum == b);
                    end else begin
                        left = left - 8'd1;
                        sum = sum + b;
                        push_item(KIND_PAYLOAD, b, count, 1'b0);
                        count = count + 8'd1;
                    end
                end
                default: begin
                    ph = (b == hdr_byte) ? PH_ID : PH_HUNT;
                end
            endcase
        endfunction

        function void check_result(input t_frame_item got);
            t_frame_item want;
            if (expected_items.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: unexpected item kind=%0d type=%h byte=%h idx=%0d ok=%0d last=%0d",
                             got.kind, got.ftype, got.pbyte, got.idx, got.ok, got.last);
                end
                return;
            end
            want = expected_items.pop_front();
            if (want !== got) begin
                errors++;
                if (errors <= 10) begin
                    $display("tb: mismatch exp kind=%0d type=%h byte=%h idx=%0d ok=%0d last=%0d",
                             want.kind, want.ftype, want.pbyte, want.idx, want.ok, want.last);
                    $display("tb:          got kind=%0d type=%h byte=%h idx=%0d ok=%0d last=%0d",
                             got.kind, got.ftype, got.pbyte, got.idx, got.ok, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_items.size();
        endfunction
    endclass

    frame_scoreboard sb;
    bit              no_idle;
    int              bytes_sent;

    sum_checked_frame_receiver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_frame_type   (o_frame_type),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_ok     (o_frame_ok),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("tb: FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        sb.note_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_results();
        stop_sending();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // idle: results drained and bytes that give no item worked through
    task automatic wait_idle();
        wait_results();
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [BYTE_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 8'($urandom_range(0, 255));
        if (r < 15) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(3, 24));
    endfunction

    task automatic send_frame(input int forced_len);
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] ftype;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        int                n;
        len = (forced_len >= 0) ? 8'(forced_len) : pick_len();
        ftype = 8'($urandom);
        if (len < SHORT_LEN && $urandom_range(0, 1) == 1) begin
            ftype = 8'd0 - len;
        end
        send_byte(sb.hdr_byte);
        send_byte(sb.dev_id - 8'd1);
        send_byte(len);
        send_byte(ftype);
        sum = len + ftype;
        if (len >= SHORT_LEN) begin
            for (n = 0; n < len - 3; n++) begin
                b = 8'($urandom);
                sum = sum + b;
                send_byte(b);
            end
            b = 8'($urandom);
            send_byte(($urandom_range(0, 3) != 0) ? sum : b);
        end
    endtask

    task automatic random_phase(input int budget);
        int start;
        int r;
        int n;
        bit paused;
        logic [BYTE_W-1:0] b;
        start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < budget) begin
            no_idle = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_frame(-1);
            end else if (r < 75) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    b = 8'($urandom);
                    send_byte(b);
                end
            end else if (r < 85) begin
                // header followed by a bad id
                send_byte(sb.hdr_byte);
                send_byte(sb.dev_id - 8'd1 + 8'($urandom_range(1, 255)));
            end else if (r < 92) begin
                send_byte(sb.hdr_byte);
                b = 8'($urandom);
                send_byte(b);
            end else begin
                // frame cut short, next bytes land in its data
                send_byte(sb.hdr_byte);
                send_byte(sb.dev_id - 8'd1);
                send_byte(8'($urandom_range(3, 40)));
                b = 8'($urandom);
                send_byte(b);
                n = $urandom_range(0, 3);
                repeat (n) begin
                    b = 8'($urandom);
                    send_byte(b);
                end
            end
            if (!paused && bytes_sent - start > budget / 2) begin
                paused = 1'b1;
                wait_results();
                @(negedge i_clk);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic run_sink();
        int          gap;
        int          taken;
        t_frame_item got;
        taken = 0;
        forever begin
            gap = draw_gap();
            // long hold so the block fills up and backs off its input
            if (taken == 150 || taken == 900) gap = 100;
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            got.kind = o_result_kind;
            got.ftype = o_frame_type;
            got.pbyte = o_payload_byte;
            got.idx = o_byte_index;
            got.ok = o_frame_ok;
            got.last = o_last;
            sb.check_result(got);
            taken++;
            @(negedge i_clk);
        end
    endtask

    initial begin
        sb = new();
        no_idle = 1'b0;
        bytes_sent = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_HEADER_BYTE;
        i_cfg_data <= '0;
        i_out_ready <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            run_sink();
        join_none
        @(negedge i_clk);

        // directed, reset config: header ff, id byte fb
        send_frame(0);
        send_byte(8'hff); send_byte(8'hfb); send_byte(8'h02); send_byte(8'hfe);
        send_byte(8'hff); send_byte(8'hfb); send_byte(8'h01); send_byte(8'h05);
        // bad id equal to header is not taken as a new header
        send_byte(8'hff); send_byte(8'hff); send_byte(8'hfb);
        // length three, checksum only
        send_byte(8'hff); send_byte(8'hfb); send_byte(8'h03); send_byte(8'h07);
        send_byte(8'h0a);
        // payload ff, 00 and a bad checksum
        send_byte(8'hff); send_byte(8'hfb); send_byte(8'h05); send_byte(8'h80);
        send_byte(8'hff); send_byte(8'h00); send_byte(8'h85);
        // id changed while the parser waits for the id byte
        send_byte(8'hff);
        wait_idle();
        write_reg(REG_DEVICE_ID, 8'h00);
        send_byte(8'hff); send_byte(8'h02); send_byte(8'hfe);

        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'h00);
        write_reg(REG_DEVICE_ID, 8'h00);
        send_frame(255);
        random_phase(20);

        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'hff);
        write_reg(REG_DEVICE_ID, 8'hff);
        random_phase(270);

        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'($urandom));
        write_reg(REG_DEVICE_ID, 8'($urandom));
        random_phase(270);

        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'($urandom));
        write_reg(REG_DEVICE_ID, 8'($urandom));
        random_phase(270);

        wait_idle();
        write_reg(REG_HEADER_BYTE, 8'h80);
        write_reg(REG_DEVICE_ID, 8'h01);
        random_phase(270);

        wait_results();
        repeat (10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
